FILE: rtl/core/morse_code_translator_core_macros.svh
// Assertion helpers shared by the translator core.
// They expect clk_i and rst_ni in the using module.
`ifndef MORSE_CODE_TRANSLATOR_CORE_MACROS_SVH
`define MORSE_CODE_TRANSLATOR_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define MCT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/mct_pkg.sv
`default_nettype none

package mct_pkg;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;

  localparam int unsigned SymCount = 36;

  // Entry = {length[2:0], elements[4:0]}, element k is bit k, dash = 1.
  localparam logic [7:0] SymTab [SymCount] = '{
    8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40,
    8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62,
    8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83,
    8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0,
    8'hA1, 8'hA3, 8'hA7, 8'hAF
  };

  typedef enum logic [1:0] {
    JOB_ENC_SYM,  // separator then the dots and dashes
    JOB_ENC_GAP,  // three spaces
    JOB_DEC       // one decoded character
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] n_res;
    logic [4:0] bits;
    logic [7:0] ch;
    logic       unk;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] bits;
  } enc_hit_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } dec_hit_t;

  function automatic logic [7:0] sym_char(logic [5:0] i);
    logic [7:0] r;
    if (i < 6'd26) begin
      r = 8'(8'h41 + {2'b00, i});
    end else begin
      r = 8'(8'h30 + {2'b00, i} - 8'd26);
    end
    return r;
  endfunction

  function automatic enc_hit_t enc_lookup(logic [7:0] c);
    enc_hit_t   r;
    logic [7:0] u;
    logic [5:0] idx;
    r   = '0;
    idx = '0;
    u   = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      u = 8'(c - 8'd32);
    end
    if (u >= 8'h41 && u <= 8'h5A) begin
      idx   = 6'(u - 8'h41);
      r.hit = 1'b1;
    end else if (u >= 8'h30 && u <= 8'h39) begin
      idx   = 6'(u - 8'h30) + 6'd26;
      r.hit = 1'b1;
    end
    if (r.hit) begin
      r.len  = SymTab[idx][7:5];
      r.bits = SymTab[idx][4:0];
    end
    return r;
  endfunction

  function automatic dec_hit_t dec_lookup(logic [2:0] len, logic [4:0] bits);
    dec_hit_t r;
    r = '0;
    for (int i = 0; i < SymCount; i++) begin
      if (SymTab[i] == {len, bits}) begin
        r.hit = 1'b1;
        r.ch  = sym_char(6'(i));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/morse_code_translator_core.sv
// A request is registered in the job queue; its first result then goes to the output register.
// Throughput: the back end emits one result per cycle unless the output stalls;
// encoded characters give a separator and up to five symbols, decoded ones at most one.
// The input keeps accepting while the request queue has room, even during output stalls.
// Reset (rst_ni low, async): mode returns to encode, decoder state and queue are cleared.
`default_nettype none

module morse_code_translator_core #(
  parameter int unsigned QueueDepth = 2  // 2 or more
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration: mode, 0 encode, 1 decode
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_mode_i,
  // input requests
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_message_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            unknown_pattern_o,
  output logic            last_of_run_o
);
  import mct_pkg::*;

  // Front end: holds mode and the decoder pattern/space state, turns each
  // request into a compact job (encode pattern, word gap, or one decoded char).
  // Requests that produce nothing are dropped here.
  logic q_full, q_empty, push, pop;
  job_t job, head;

  mct_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_mode_i       (cfg_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_char_i        (in_char_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (job)
  );

  // Job queue decouples classification from symbol emission.
  mct_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Back end: walks the head job one character per cycle, when the output is not stalled,
  // into the output register; the last character of a job pops it and carries last_of_run.
  mct_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (q_empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_char_o        (out_char_o),
    .unknown_pattern_o (unknown_pattern_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mct_front.sv
`default_nettype none

module mct_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_mode_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_char_i,
  input  wire logic          end_of_message_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output mct_pkg::job_t      job_o
);
  import mct_pkg::*;

  logic       mode_q;
  logic [4:0] pb_q, pb_d;
  logic [2:0] pl_q, pl_d;
  logic       po_q, po_d;
  logic [1:0] sr_q, sr_d;

  logic       accept;
  logic       is_elem, is_space;
  logic [4:0] pb1;
  logic [2:0] pl1;
  logic       po1;
  logic       flush, letter, gap;
  enc_hit_t   enc;
  dec_hit_t   dec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && !q_full_i;

  assign is_elem  = (in_char_i == CharDot) || (in_char_i == CharDash);
  assign is_space = (in_char_i == CharSpace);
  assign enc      = enc_lookup(in_char_i);

  // decode: element first, then flush on first space or end of message
  always_comb begin
    pb1 = pb_q;
    pl1 = pl_q;
    po1 = po_q;
    if (is_elem) begin
      if (pl_q >= 3'd5) begin
        po1 = 1'b1;
      end else begin
        if (in_char_i == CharDash) begin
          pb1 = pb_q | (5'b00001 << pl_q);
        end
        pl1 = pl_q + 3'd1;
      end
    end
  end

  assign dec    = dec_lookup(pl1, pb1);
  assign flush  = (is_space && sr_q == 2'd0) || end_of_message_i;
  assign letter = flush && (pl1 != 3'd0 || po1);
  assign gap    = is_space && sr_q >= 2'd2;

  always_comb begin
    pb_d = pb1;
    pl_d = pl1;
    po_d = po1;
    sr_d = sr_q;
    if (letter) begin
      pb_d = '0;
      pl_d = '0;
      po_d = 1'b0;
    end
    if (is_elem) begin
      sr_d = 2'd0;
    end else if (is_space) begin
      sr_d = gap ? 2'd0 : sr_q + 2'd1;
    end
    if (end_of_message_i) begin
      sr_d = 2'd0;
    end
  end

  always_comb begin
    job_o = '0;
    if (!mode_q) begin
      if (is_space) begin
        job_o.kind  = JOB_ENC_GAP;
        job_o.n_res = 3'd3;
      end else begin
        job_o.kind  = JOB_ENC_SYM;
        job_o.n_res = enc.hit ? enc.len + 3'd1 : 3'd1;
        job_o.bits  = enc.bits;
      end
    end else begin
      job_o.kind = JOB_DEC;
      if (letter) begin
        job_o.n_res = 3'd1;
        job_o.ch    = (!po1 && dec.hit) ? dec.ch : CharNul;
        job_o.unk   = po1 || !dec.hit;
      end else if (gap) begin
        job_o.n_res = 3'd1;
        job_o.ch    = CharSpace;
      end
    end
  end

  assign push_o = accept && (job_o.n_res != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pb_q   <= '0;
      pl_q   <= '0;
      po_q   <= 1'b0;
      sr_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_mode_i;
      end
      if (accept && mode_q) begin
        pb_q <= pb_d;
        pl_q <= pl_d;
        po_q <= po_d;
        sr_q <= sr_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mct_queue.sv
`default_nettype none
`include "morse_code_translator_core_macros.svh"

module mct_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mct_pkg::job_t job_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               empty_o,
  output mct_pkg::job_t      head_o
);
  import mct_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `MCT_ASSERT_NEVER(a_push_full, push_i && full_o, "request pushed into full queue")
  `MCT_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")
  `MCT_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count out of range")
  `MCT_ASSERT(a_count_up, (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1, "count stuck")

endmodule

`default_nettype wire

FILE: rtl/core/mct_back.sv
`default_nettype none
`include "morse_code_translator_core_macros.svh"

module mct_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire mct_pkg::job_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               unknown_pattern_o,
  output logic               last_of_run_o
);
  import mct_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_unk_q, out_last_q;
  logic [2:0] idx_q, idx_d;
  logic [2:0] el;
  logic       load, last;
  logic [7:0] ch;
  logic       unk;

  assign load = !empty_i && (!out_valid_q || out_ready_i);
  assign last = (idx_q == head_i.n_res - 3'd1);
  assign el   = idx_q - 3'd1;

  always_comb begin
    ch  = CharNul;
    unk = 1'b0;
    unique case (head_i.kind)
      JOB_ENC_SYM: begin
        if (idx_q == 3'd0) begin
          ch = CharSpace;
        end else begin
          ch = head_i.bits[el] ? CharDash : CharDot;
        end
      end
      JOB_ENC_GAP: ch = CharSpace;
      JOB_DEC: begin
        ch  = head_i.ch;
        unk = head_i.unk;
      end
      default: ch = CharNul;
    endcase
  end

  assign pop_o = load && last;
  assign idx_d = load ? (last ? 3'd0 : idx_q + 3'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= ch;
      out_unk_q  <= unk;
      out_last_q <= last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_char_o        = out_char_q;
  assign unknown_pattern_o = out_unk_q;
  assign last_of_run_o     = out_last_q;

  `MCT_ASSERT(a_idx_range, !empty_i |-> (idx_q < head_i.n_res), "symbol index beyond request")
  `MCT_ASSERT(a_stall_idx, (out_valid_q && !out_ready_i) |=> $stable(idx_q), "stalled idx moved")
  `MCT_ASSERT(a_enc_known, (load && head_i.kind != JOB_DEC) |=> !out_unk_q, "unk set on encode")

endmodule

`default_nettype wire
